[design/escu_pkg.sv]
// Shared types and character constants for the escape sequence unescaper.
// Used by escu_decode and escape_sequence_unescaper; depends on nothing.
package escu_pkg;

   localparam int unsigned MaxOut = 4;   // most bytes one input byte can produce
   localparam int unsigned CntW   = 3;   // holds 0..MaxOut

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_CARET     = 8'h5E;
   localparam logic [7:0] CH_AT        = 8'h40;
   localparam logic [7:0] CH_UNDER     = 8'h5F;
   localparam logic [7:0] CH_QMARK     = 8'h3F;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;
   localparam logic [7:0] CH_UPPER_U   = 8'h55;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_DEL       = 8'h7F;

   localparam logic [3:0] DIGITS_SHORT = 4'd4;
   localparam logic [3:0] DIGITS_LONG  = 4'd8;

   localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;
   localparam logic [31:0] SURR_LO     = 32'h0000_D800;
   localparam logic [31:0] SURR_HI     = 32'h0000_DFFF;

   // Everything one request produces, handed from the decoder to the output buffer.
   typedef struct packed {
      logic [CntW-1:0]         count;
      logic [MaxOut-1:0][7:0]  bytes;   // bytes[0] goes out first
      logic                    err;
      logic                    str_end;
   } result_type;

endpackage

[design/escu_decode.sv]
// Escape parser: holds the parse state and turns one request byte into up to
// four result bytes combinationally. Depends on escu_pkg.
module escu_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output escu_pkg::result_type result
);
   import escu_pkg::*;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_ESC,
      MODE_CARET,
      MODE_HEX
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [3:0]  digits_ff, digits_in;
   logic [31:0] acc_ff, acc_in;

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [31:0] acc_next;
   logic [3:0]  digits_dec;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
         hex_val = 4'(in_byte - CH_ZERO);
      end else if (in_byte >= CH_UPPER_A && in_byte <= CH_UPPER_F) begin
         hex_val = 4'(in_byte - CH_UPPER_A + 8'd10);
      end else if (in_byte >= CH_LOWER_A && in_byte <= CH_LOWER_F) begin
         hex_val = 4'(in_byte - CH_LOWER_A + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_next   = {acc_ff[27:0], hex_val};
   assign digits_dec = digits_ff - 4'd1;

   always_comb begin
      mode_in        = mode_ff;
      digits_in      = digits_ff;
      acc_in         = acc_ff;
      result         = '0;
      result.str_end = in_last;

      unique case (mode_ff)
         MODE_NORMAL: begin
            if (in_byte == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               result.count    = CntW'(1);
               result.bytes[0] = in_byte;
            end
         end
         MODE_ESC: begin
            mode_in      = MODE_NORMAL;
            result.count = CntW'(1);
            case (in_byte) inside
               CH_ZERO:      result.bytes[0] = 8'd0;
               8'h61:        result.bytes[0] = 8'd7;    // a
               8'h62:        result.bytes[0] = 8'd8;    // b
               8'h74:        result.bytes[0] = 8'd9;    // t
               8'h6E:        result.bytes[0] = 8'd10;   // n
               8'h76:        result.bytes[0] = 8'd11;   // v
               8'h66:        result.bytes[0] = 8'd12;   // f
               8'h72:        result.bytes[0] = 8'd13;   // r
               8'h65:        result.bytes[0] = 8'd27;   // e
               CH_QUOTE:     result.bytes[0] = CH_QUOTE;
               CH_BACKSLASH: result.bytes[0] = CH_BACKSLASH;
               CH_CARET: begin
                  mode_in      = MODE_CARET;
                  result.count = '0;
               end
               CH_LOWER_U, CH_UPPER_U: begin
                  mode_in      = MODE_HEX;
                  digits_in    = (in_byte == CH_LOWER_U) ? DIGITS_SHORT : DIGITS_LONG;
                  acc_in       = '0;
                  result.count = '0;
               end
               default: result.err = 1'b1;
            endcase
         end
         MODE_CARET: begin
            mode_in      = MODE_NORMAL;
            result.count = CntW'(1);
            if (in_byte >= CH_AT && in_byte <= CH_UNDER) begin
               result.bytes[0] = in_byte - CH_AT;
            end else if (in_byte == CH_QMARK) begin
               result.bytes[0] = CH_DEL;
            end else begin
               result.err = 1'b1;
            end
         end
         MODE_HEX: begin
            if (!hex_ok) begin
               mode_in      = MODE_NORMAL;
               digits_in    = '0;
               result.count = CntW'(1);
               result.err   = 1'b1;
            end else begin
               acc_in    = acc_next;
               digits_in = digits_dec;
               if (digits_dec == 4'd0 || digits_dec > DIGITS_LONG) begin
                  digits_in = '0;
                  mode_in   = MODE_NORMAL;
                  // UTF-8 encode; out-of-range and surrogate values are errors
                  if (acc_next > CP_MAX || (acc_next >= SURR_LO && acc_next <= SURR_HI)) begin
                     result.count = CntW'(1);
                     result.err   = 1'b1;
                  end else if (acc_next < 32'h80) begin
                     result.count    = CntW'(1);
                     result.bytes[0] = acc_next[7:0];
                  end else if (acc_next < 32'h800) begin
                     result.count    = CntW'(2);
                     result.bytes[0] = {3'b110, acc_next[10:6]};
                     result.bytes[1] = {2'b10, acc_next[5:0]};
                  end else if (acc_next < 32'h1_0000) begin
                     result.count    = CntW'(3);
                     result.bytes[0] = {4'b1110, acc_next[15:12]};
                     result.bytes[1] = {2'b10, acc_next[11:6]};
                     result.bytes[2] = {2'b10, acc_next[5:0]};
                  end else begin
                     result.count    = CntW'(4);
                     result.bytes[0] = {5'b11110, acc_next[20:18]};
                     result.bytes[1] = {2'b10, acc_next[17:12]};
                     result.bytes[2] = {2'b10, acc_next[11:6]};
                     result.bytes[3] = {2'b10, acc_next[5:0]};
                  end
               end
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
         end
      endcase

      // string ended inside an escape: nothing was produced above in that case
      if (in_last && mode_in != MODE_NORMAL) begin
         result.count = CntW'(1);
         result.bytes = '0;
         result.err   = 1'b1;
         mode_in      = MODE_NORMAL;
         digits_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         digits_ff <= '0;
         acc_ff    <= '0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

[design/escape_sequence_unescaper.sv]
// Top level of the escape sequence unescaper: parser plus a four-byte result
// buffer that drains one byte per cycle while rsp_tready is high. Depends on
// escu_pkg and escu_decode.
//   channel | direction | tdata          | tuser                    | tlast
//   req     | in        | [7:0] in_byte  | -                        | in_last
//   rsp     | out       | [7:0] out_byte | [0] run_last, [1] error  | string_end
//
// A request is parsed in the cycle it is taken; its results sit in the result
// buffer from the next cycle on, one leaving per cycle while rsp is ready.
// Single-byte results sustain one request per cycle while rsp_tready is high.
// A multi-byte UTF-8 result holds off requests until its last byte leaves.
// req_tready is high when the buffer is empty or its last byte leaves now.
// Synchronous reset returns the parser to normal mode and empties the buffer.
module escape_sequence_unescaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic [1:0] rsp_tuser,    // [0] run_last, [1] error
   output logic       rsp_tlast
);
   import escu_pkg::*;

   result_type             dec_result;
   logic [MaxOut-1:0][7:0] buf_ff;
   logic [CntW-1:0]        cnt_ff;
   logic                   err_ff;
   logic                   end_ff;
   logic                   req_fire;
   logic                   rsp_fire;
   logic                   final_one;

   assign final_one  = (cnt_ff == CntW'(1));
   assign rsp_tvalid = (cnt_ff != '0);
   assign req_tready = (cnt_ff == '0) || (final_one && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   escu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (req_fire),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .result  (dec_result)
   );

   assign rsp_tdata    = buf_ff[0];
   assign rsp_tuser[0] = final_one;
   assign rsp_tuser[1] = err_ff;
   assign rsp_tlast    = end_ff && final_one;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req_fire) begin
         cnt_ff <= dec_result.count;
      end else if (rsp_fire) begin
         cnt_ff <= cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         buf_ff <= dec_result.bytes;
         err_ff <= dec_result.err;
         end_ff <= dec_result.str_end;
      end else if (rsp_fire) begin
         buf_ff <= {8'h00, buf_ff[MaxOut-1:1]};
      end
   end

endmodule

[design/escu_checker.sv]
// Port-level checks for escape_sequence_unescaper, attached with bind.
// Depends only on the top level's ports.
module escu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // error results carry a zero byte and are the only result of their request
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 8'h00 && rsp_tuser[0])
      else $error("error result malformed");

   a_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("string end without run end");

   // every final byte of a string produces at least one result
   a_last_out: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("final request produced no result");

   // more bytes of the same request pending: no new request taken
   a_multi_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !req_tready)
      else $error("request taken while buffer busy");

endmodule

bind escape_sequence_unescaper escu_checker u_escu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[tb/sv/unescape_checker.sv]
// Checker for the escape sequence unescaper: watches both streams, decodes each
// accepted request into the bytes it should yield, and compares them in order.
// Depends on escu_pkg for the character constants and code point limits.
module unescape_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [1:0] rsp_tuser,
   input  logic       rsp_tlast,
   output int         mismatch_count,
   output int         outstanding_bytes,
   output int         bytes_checked
);
   import escu_pkg::*;

   typedef enum logic [1:0] {
      PARSE_TEXT,
      PARSE_ESCAPE,
      PARSE_CARET,
      PARSE_HEX
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       string_end;
      logic       error;
   } unescaped_byte_type;

   parse_mode_type     parse_mode;
   logic [3:0]         digits_left;
   logic [31:0]        code_point;
   unescaped_byte_type expected_bytes[$];

   function automatic unescaped_byte_type plain(input logic [7:0] value);
      unescaped_byte_type r;
      r = '0;
      r.data = value;
      return r;
   endfunction

   function automatic unescaped_byte_type flagged();
      unescaped_byte_type r;
      r = '0;
      r.error = 1'b1;
      return r;
   endfunction

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
      return -1;
   endfunction

   // Works out the bytes one request yields and queues them.
   task automatic decode_request(input logic [7:0] b, input logic last);
      unescaped_byte_type burst[MaxOut+1];
      int                 n;
      int                 nib;
      n = 0;
      case (parse_mode)
         PARSE_TEXT: begin
            if (b == CH_BACKSLASH) begin
               parse_mode = PARSE_ESCAPE;
            end else begin
               burst[0] = plain(b);
               n = 1;
            end
         end
         PARSE_ESCAPE: begin
            parse_mode = PARSE_TEXT;
            n = 1;
            case (b) inside
               CH_ZERO:      burst[0] = plain(8'd0);
               "a":          burst[0] = plain(8'd7);
               "b":          burst[0] = plain(8'd8);
               "t":          burst[0] = plain(8'd9);
               "n":          burst[0] = plain(8'd10);
               "v":          burst[0] = plain(8'd11);
               "f":          burst[0] = plain(8'd12);
               "r":          burst[0] = plain(8'd13);
               "e":          burst[0] = plain(8'd27);
               CH_QUOTE:     burst[0] = plain(CH_QUOTE);
               CH_BACKSLASH: burst[0] = plain(CH_BACKSLASH);
               CH_CARET: begin
                  parse_mode = PARSE_CARET;
                  n = 0;
               end
               CH_LOWER_U, CH_UPPER_U: begin
                  parse_mode = PARSE_HEX;
                  digits_left = (b == CH_LOWER_U) ? DIGITS_SHORT : DIGITS_LONG;
                  code_point = '0;
                  n = 0;
               end
               default:      burst[0] = flagged();
            endcase
         end
         PARSE_CARET: begin
            parse_mode = PARSE_TEXT;
            n = 1;
            if (b >= CH_AT && b <= CH_UNDER) burst[0] = plain(b - CH_AT);
            else if (b == CH_QMARK) burst[0] = plain(CH_DEL);
            else burst[0] = flagged();
         end
         default: begin
            nib = hex_nibble(b);
            if (nib < 0) begin
               parse_mode = PARSE_TEXT;
               digits_left = '0;
               burst[0] = flagged();
               n = 1;
            end else begin
               code_point = {code_point[27:0], nib[3:0]};
               digits_left = digits_left - 4'd1;
               if (digits_left == 4'd0 || digits_left > DIGITS_LONG) begin
                  digits_left = '0;
                  parse_mode = PARSE_TEXT;
                  if (code_point > CP_MAX ||
                      (code_point >= SURR_LO && code_point <= SURR_HI)) begin
                     burst[0] = flagged();
                     n = 1;
                  end else if (code_point < 32'h80) begin
                     burst[0] = plain(code_point[7:0]);
                     n = 1;
                  end else if (code_point < 32'h800) begin
                     burst[0] = plain({3'b110, code_point[10:6]});
                     burst[1] = plain({2'b10, code_point[5:0]});
                     n = 2;
                  end else if (code_point < 32'h1_0000) begin
                     burst[0] = plain({4'b1110, code_point[15:12]});
                     burst[1] = plain({2'b10, code_point[11:6]});
                     burst[2] = plain({2'b10, code_point[5:0]});
                     n = 3;
                  end else begin
                     burst[0] = plain({5'b11110, code_point[20:18]});
                     burst[1] = plain({2'b10, code_point[17:12]});
                     burst[2] = plain({2'b10, code_point[11:6]});
                     burst[3] = plain({2'b10, code_point[5:0]});
                     n = 4;
                  end
               end
            end
         end
      endcase

      // string ends inside an escape: one extra error byte closes it
      if (last && parse_mode != PARSE_TEXT) begin
         burst[n] = flagged();
         n = n + 1;
         parse_mode = PARSE_TEXT;
         digits_left = '0;
      end
      if (n > 0) begin
         burst[n-1].run_last = 1'b1;
         burst[n-1].string_end = last;
      end
      for (int i = 0; i < n; i++) expected_bytes.push_back(burst[i]);
   endtask

   always @(posedge clock) begin
      unescaped_byte_type want;
      unescaped_byte_type got;
      if (reset) begin
         parse_mode = PARSE_TEXT;
         digits_left = '0;
         code_point = '0;
         expected_bytes.delete();
         mismatch_count <= 0;
         outstanding_bytes <= 0;
         bytes_checked <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]};
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected result: data=%h run_last=%b string_end=%b error=%b",
                        $time, got.data, got.run_last, got.string_end, got.error);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_bytes.pop_front();
               if (got.data !== want.data || got.run_last !== want.run_last ||
                   got.string_end !== want.string_end || got.error !== want.error) begin
                  // flags in the order run_last, string_end, error
                  $display("%0t: mismatch: expected %h %b%b%b, got %h %b%b%b",
                           $time, want.data, want.run_last, want.string_end, want.error,
                           got.data, got.run_last, got.string_end, got.error);
                  mismatch_count <= mismatch_count + 1;
               end
               bytes_checked <= bytes_checked + 1;
            end
         end
         if (req_tvalid && req_tready) decode_request(req_tdata, req_tlast);
         outstanding_bytes <= expected_bytes.size();
      end
   end

endmodule

[tb/sv/testbench.sv]
// Top of the escape sequence unescaper testbench: clock, reset, request stimulus
// and the verdict. Depends on escu_pkg, escape_sequence_unescaper, unescape_checker.
module testbench;
   import escu_pkg::*;

   localparam int StallLimit  = 400;   // cycles with no handshake before giving up
   localparam int RandomBytes = 180;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   int         mismatch_count;
   int         outstanding_bytes;
   int         bytes_checked;
   int         stall_cycles;
   int         bytes_sent;
   int         strings_sent;
   bit         steady;          // no idling on either side while set
   logic [7:0] text_q[$];

   logic [7:0] simple_letters[11] = '{"0", "a", "b", "t", "n", "v", "f", "r", "e",
                                      CH_QUOTE, CH_BACKSLASH};

   escape_sequence_unescaper u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   unescape_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast),
      .mismatch_count    (mismatch_count),
      .outstanding_bytes (outstanding_bytes),
      .bytes_checked     (bytes_checked)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 37);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == StallLimit) begin
            $display("%0t: no handshake for %0d cycles", $time, StallLimit);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   task automatic add_chars(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // pushes the low digits of value as hex, most significant first, in mixed case
   task automatic add_hex(input logic [31:0] value, input int digits);
      logic [3:0] nib;
      for (int i = digits - 1; i >= 0; i--) begin
         nib = value[i*4 +: 4];
         if (nib < 4'd10) text_q.push_back(CH_ZERO + {4'h0, nib});
         else text_q.push_back(($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A)
                               + {4'h0, nib} - 8'd10);
      end
   endtask

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255));
      end while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
                 (c >= CH_LOWER_A && c <= CH_LOWER_F));
      return c;
   endfunction

   task automatic add_random_token();
      int         pick;
      logic [7:0] c;
      logic [31:0] cp;
      pick = $urandom_range(99);
      if (pick < 30) begin
         c = 8'($urandom_range(255));
         if (c == CH_BACKSLASH) text_q.push_back(CH_BACKSLASH);
         text_q.push_back(c);
      end else if (pick < 45) begin
         text_q.push_back(CH_BACKSLASH);
         text_q.push_back(simple_letters[$urandom_range(10)]);
      end else if (pick < 55) begin
         text_q.push_back(CH_BACKSLASH);
         text_q.push_back(CH_CARET);
         text_q.push_back(($urandom_range(7) == 0) ? CH_QMARK
                                                   : CH_AT + 8'($urandom_range(31)));
      end else if (pick < 75) begin
         case ($urandom_range(3))
            0:       cp = $urandom_range(32'h7F);
            1:       cp = $urandom_range(32'h7FF, 32'h80);
            2:       cp = $urandom_range(32'hFFFF, 32'h800);
            default: cp = $urandom_range(SURR_HI, SURR_LO);
         endcase
         text_q.push_back(CH_BACKSLASH);
         text_q.push_back(CH_LOWER_U);
         add_hex(cp, 4);
      end else if (pick < 85) begin
         case ($urandom_range(3))
            0: cp = $urandom_range(32'hFFFF);
            1: cp = $urandom_range(CP_MAX, 32'h1_0000);
            2: begin
               cp = $urandom;
               if (cp <= CP_MAX) cp[31] = 1'b1;
            end
            default: begin
               case ($urandom_range(2))
                  0:       cp = 32'hFFFF_FFFF;
                  1:       cp = CP_MAX;
                  default: cp = CP_MAX + 32'd1;
               endcase
            end
         endcase
         text_q.push_back(CH_BACKSLASH);
         text_q.push_back(CH_UPPER_U);
         add_hex(cp, 8);
      end else if (pick < 92) begin
         // arbitrary escape letter, mostly malformed
         text_q.push_back(CH_BACKSLASH);
         text_q.push_back(8'($urandom_range(255)));
      end else if (pick < 96) begin
         text_q.push_back(CH_BACKSLASH);
         text_q.push_back(CH_CARET);
         text_q.push_back(8'($urandom_range(255)));
      end else begin
         // hex escape broken by a non-digit
         text_q.push_back(CH_BACKSLASH);
         if ($urandom_range(1)) begin
            text_q.push_back(CH_LOWER_U);
            add_hex($urandom, $urandom_range(3));
         end else begin
            text_q.push_back(CH_UPPER_U);
            add_hex($urandom, $urandom_range(7));
         end
         text_q.push_back(non_hex_byte());
      end
   endtask

   // string cut off inside an escape
   task automatic add_partial_escape();
      text_q.push_back(CH_BACKSLASH);
      case ($urandom_range(3))
         0: ;
         1: text_q.push_back(CH_CARET);
         2: begin
            text_q.push_back(CH_LOWER_U);
            add_hex($urandom, $urandom_range(3));
         end
         default: begin
            text_q.push_back(CH_UPPER_U);
            add_hex($urandom, $urandom_range(7));
         end
      endcase
   endtask

   // sends text_q as one string, tlast on its final byte
   task automatic send_text();
      foreach (text_q[i]) begin
         @(negedge clock);
         while (!steady && $urandom_range(99) < 37) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= text_q[i];
         req_tlast <= (i == text_q.size() - 1);
         do @(posedge clock); while (!req_tready);
         bytes_sent++;
      end
      text_q.delete();
      strings_sent++;
   endtask

   initial begin
      int start_bytes;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      steady = 1'b0;
      stall_cycles = 0;
      bytes_sent = 0;
      strings_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: byte extremes, backslash and DEL escapes, bad caret, unknown
      // letter, surrogate, bad hex digit, zero byte after backslash, truncation
      text_q = {8'h00, 8'hFF};
      send_text();
      add_chars("\\\\\\^?");
      send_text();
      add_chars("\\^x\\z");
      send_text();
      add_chars("\\uD800");
      send_text();
      add_chars("\\u12G\\");
      text_q.push_back(8'h00);
      text_q.push_back(CH_BACKSLASH);
      send_text();

      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RandomBytes) begin
         steady = (bytes_sent - start_bytes >= 80) && (bytes_sent - start_bytes < 130);
         repeat ($urandom_range(1, 6)) add_random_token();
         if ($urandom_range(99) < 15) add_partial_escape();
         send_text();
      end
      steady = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding_bytes != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Sent %0d strings (%0d bytes): plain bytes, every escape kind,",
               strings_sent, bytes_sent);
      $display("UTF-8 of 1 to 4 bytes, bad and truncated escapes; %0d results checked.",
               bytes_checked);
      if (mismatch_count == 0 && outstanding_bytes == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
